### hdl/kpbc_pkg.sv
// ----------------------------------------------------------------------------
// kpbc_pkg: shared types and constants for the keyed Polybius byte cipher
// Status codes, controller states, and the command and status groups that
// join the controller to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package kpbc_pkg;

	localparam int unsigned ALPHABET_SIZE = 256;
	localparam int unsigned BYTE_W        = 8;
	localparam int unsigned FILL_W        = 9;
	localparam int unsigned STATUS_W      = 3;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 3'd0,
		ST_READY    = 3'd1,
		ST_NOKEY    = 3'd2,
		ST_BADCOORD = 3'd3,
		ST_ODD      = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_FILL,
		S_ENC_ROW,
		S_ENC_COL,
		S_DEC_OUT
	} state_t;

	typedef enum logic [1:0] {
		SEL_ZERO,
		SEL_ROW,
		SEL_COL,
		SEL_TABLE
	} emit_sel_t;

	typedef struct packed {
		logic      key_place;
		logic      fill_start;
		logic      fill_step;
		logic      enc_read;
		logic      dec_read;
		logic      hold_row;
		logic      drop_row;
		logic      emit;
		emit_sel_t emit_sel;
		status_t   emit_status;
		logic      emit_last;
	} cmd_t;

	typedef struct packed {
		logic table_ready;
		logic pending;
		logic mode;
		logic bad_coord;
		logic fill_done;
	} stat_t;

endpackage

`default_nettype wire

### hdl/kpbc_ctrl.sv
// ----------------------------------------------------------------------------
// kpbc_ctrl: request sequencer
// Decodes each accepted request against the datapath status and steps the
// table fill, encrypt and decrypt sequences.
// ----------------------------------------------------------------------------
`default_nettype none

module kpbc_ctrl
	import kpbc_pkg::*;
(
	input  wire   clk,
	input  wire   arst_n,
	input  wire   start,
	input  wire   opcode,
	input  wire   last,
	input  stat_t stat,
	output logic  busy,
	output cmd_t  cmd
);

	state_t state_q;
	state_t state_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_n;
		end
	end

	always_comb begin
		state_n = state_q;
		busy    = (state_q != S_IDLE);
		cmd     = '0;
		cmd.emit_sel    = SEL_ZERO;
		cmd.emit_status = ST_OK;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (!opcode) begin
						cmd.key_place = 1'b1;
						if (last) begin
							cmd.fill_start = 1'b1;
							state_n        = S_FILL;
						end
					end else if (!stat.table_ready) begin
						cmd.drop_row    = 1'b1;
						cmd.emit        = 1'b1;
						cmd.emit_status = ST_NOKEY;
						cmd.emit_last   = 1'b1;
					end else if (!stat.mode) begin
						cmd.drop_row = 1'b1;
						cmd.enc_read = 1'b1;
						state_n      = S_ENC_ROW;
					end else if (!stat.pending) begin
						if (last) begin
							cmd.emit        = 1'b1;
							cmd.emit_status = ST_ODD;
							cmd.emit_last   = 1'b1;
						end else begin
							cmd.hold_row = 1'b1;
						end
					end else begin
						cmd.drop_row = 1'b1;
						if (stat.bad_coord) begin
							cmd.emit        = 1'b1;
							cmd.emit_status = ST_BADCOORD;
							cmd.emit_last   = 1'b1;
						end else begin
							cmd.dec_read = 1'b1;
							state_n      = S_DEC_OUT;
						end
					end
				end
			end
			S_FILL: begin
				cmd.fill_step = 1'b1;
				if (stat.fill_done) begin
					cmd.emit        = 1'b1;
					cmd.emit_status = ST_READY;
					cmd.emit_last   = 1'b1;
					state_n         = S_IDLE;
				end
			end
			S_ENC_ROW: begin
				cmd.emit     = 1'b1;
				cmd.emit_sel = SEL_ROW;
				state_n      = S_ENC_COL;
			end
			S_ENC_COL: begin
				cmd.emit      = 1'b1;
				cmd.emit_sel  = SEL_COL;
				cmd.emit_last = 1'b1;
				state_n       = S_IDLE;
			end
			S_DEC_OUT: begin
				cmd.emit      = 1'b1;
				cmd.emit_sel  = SEL_TABLE;
				cmd.emit_last = 1'b1;
				state_n       = S_IDLE;
			end
			default: begin
				state_n = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### hdl/kpbc_dpath.sv
// ----------------------------------------------------------------------------
// kpbc_dpath: square storage and result registers
// Holds the square and its inverse in two memories, the used marks, the fill
// counters, the held decrypt row, the mode register and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module kpbc_dpath
	import kpbc_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire  [BYTE_W-1:0]   data_byte,
	input  wire                 cfg_valid,
	input  wire                 cfg_data,
	input  cmd_t                cmd,
	output stat_t               stat,
	output logic                strobe,
	output logic [BYTE_W-1:0]   out_byte,
	output logic [STATUS_W-1:0] status,
	output logic                last_of_run
);

	logic [BYTE_W-1:0]        sq_mem [ALPHABET_SIZE];
	logic [BYTE_W-1:0]        pos_mem [ALPHABET_SIZE];
	logic [BYTE_W-1:0]        sq_rd_q;
	logic [BYTE_W-1:0]        pos_rd_q;
	logic [ALPHABET_SIZE-1:0] used_q;
	logic [ALPHABET_SIZE-1:0] used_n;
	logic [FILL_W-1:0]        fill_q;
	logic [BYTE_W-1:0]        vcnt_q;
	logic                     ready_q;
	logic                     pend_q;
	logic [BYTE_W-1:0]        row_q;
	logic                     mode_q;

	logic                     clear;
	logic [BYTE_W-1:0]        pl_byte;
	logic [FILL_W-1:0]        pl_base;
	logic                     pl_used;
	logic                     pl_en;
	logic [BYTE_W-1:0]        dec_addr;

	assign clear    = cmd.key_place && (ready_q || (fill_q == '0));
	assign pl_byte  = cmd.key_place ? data_byte : vcnt_q;
	assign pl_base  = clear ? '0 : fill_q;
	assign pl_used  = clear ? 1'b0 : used_q[pl_byte];
	assign pl_en    = (cmd.key_place || cmd.fill_step) && !pl_used && !pl_base[FILL_W-1];
	assign dec_addr = {row_q[3:0], data_byte[3:0]};

	assign stat.table_ready = ready_q;
	assign stat.pending     = pend_q;
	assign stat.mode        = mode_q;
	assign stat.bad_coord   = (row_q[7:4] != '0) || (data_byte[7:4] != '0);
	assign stat.fill_done   = (vcnt_q == {BYTE_W{1'b1}});

	always_comb begin
		used_n = used_q;
		if (clear) begin
			used_n = '0;
		end
		if (pl_en) begin
			used_n[pl_byte] = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pl_en) begin
			sq_mem[pl_base[BYTE_W-1:0]] <= pl_byte;
			pos_mem[pl_byte]            <= pl_base[BYTE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.dec_read) begin
			sq_rd_q <= sq_mem[dec_addr];
		end
		if (cmd.enc_read) begin
			pos_rd_q <= pos_mem[data_byte];
		end
		if (cmd.hold_row) begin
			row_q <= data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q  <= '0;
			fill_q  <= '0;
			vcnt_q  <= '0;
			ready_q <= 1'b0;
			pend_q  <= 1'b0;
			mode_q  <= 1'b0;
		end else begin
			used_q <= used_n;
			if (cfg_valid) begin
				mode_q <= cfg_data;
			end
			if (pl_en) begin
				fill_q <= pl_base + FILL_W'(1);
			end else if (clear) begin
				fill_q <= '0;
			end
			if (cmd.fill_start) begin
				vcnt_q <= '0;
			end else if (cmd.fill_step) begin
				vcnt_q <= vcnt_q + BYTE_W'(1);
			end
			if (clear) begin
				ready_q <= 1'b0;
			end else if (cmd.fill_step && stat.fill_done) begin
				ready_q <= 1'b1;
			end
			if (clear || cmd.drop_row) begin
				pend_q <= 1'b0;
			end else if (cmd.hold_row) begin
				pend_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			status      <= cmd.emit_status;
			last_of_run <= cmd.emit_last;
			case (cmd.emit_sel)
				SEL_ROW:   out_byte <= {4'd0, pos_rd_q[7:4]};
				SEL_COL:   out_byte <= {4'd0, pos_rd_q[3:0]};
				SEL_TABLE: out_byte <= sq_rd_q;
				default:   out_byte <= '0;
			endcase
		end
	end

endmodule

`default_nettype wire

### hdl/keyed_polybius_byte_cipher.sv
// ----------------------------------------------------------------------------
// keyed_polybius_byte_cipher: keyed 16x16 Polybius square over bytes
// Results appear for exactly one cycle with strobe high and cannot be stalled;
// the receiver must take every strobed result. A request is taken when start
// is high and busy is low. An encrypt request steps through a position memory
// read, then the row and then the column result, and a decrypt second byte
// through a square memory read and then the byte result. The last key byte
// starts a fill that walks all 256 byte values, one per cycle, before the
// table ready result. The user must write the mode register through
// cfg_valid/cfg_data only while idle; the block itself does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

module keyed_polybius_byte_cipher
	import kpbc_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 start,
	output logic                busy,
	input  wire                 opcode,
	input  wire  [BYTE_W-1:0]   data_byte,
	input  wire                 last,
	input  wire                 cfg_valid,
	output logic                cfg_ready,
	input  wire                 cfg_data,
	output logic                strobe,
	output logic [BYTE_W-1:0]   out_byte,
	output logic [STATUS_W-1:0] status,
	output logic                last_of_run
);

	cmd_t  cmd;
	stat_t stat;

	assign cfg_ready = 1'b1;

	kpbc_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.last   (last),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	kpbc_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.data_byte   (data_byte),
		.cfg_valid   (cfg_valid),
		.cfg_data    (cfg_data),
		.cmd         (cmd),
		.stat        (stat),
		.strobe      (strobe),
		.out_byte    (out_byte),
		.status      (status),
		.last_of_run (last_of_run)
	);

endmodule

`default_nettype wire
